// ----- sv/svj_pkg.sv -----
`timescale 1ns / 1ps
// svj_pkg: shared widths, codes and types of the similarity 3D versor jacobian unit
// depends on nothing; used by every module of the block
package svj_pkg;

  // coordinate format
  localparam int COORD_FRAC_BITS = 8;
  localparam int PT_W   = 20;               // point and packed coordinate fields
  localparam int P_W    = PT_W + 1;         // point minus center
  localparam int V_W    = 16;               // versor components
  localparam int PRD_W  = 2 * V_W;          // versor products
  localparam int CF_W   = PRD_W + 2;        // polynomial and rotation matrix coefficients
  localparam int PR_W   = CF_W + P_W;       // coefficient times offset
  localparam int SUM_W  = PR_W + 2;         // sum of three products
  localparam int NUM_W  = SUM_W + 2;        // doubled and negated numerator
  localparam int DEN_SHIFT = 14;            // w scale in Q2.14
  localparam int DIVN_W = NUM_W - DEN_SHIFT; // dividend after removing the 2^14 factor
  localparam int Q_W    = 36;               // quotient bits developed by the divider
  localparam int HI_W   = DIVN_W - Q_W;     // dividend bits above the quotient range
  localparam int DIV_STEPS  = 4;            // quotient bits per divider stage
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int VAL_W  = 34;               // scale row value before clipping
  localparam int D_W    = 32;               // derivative width
  localparam int ROW_W  = 3;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 60;
  localparam int ROT_ONE_SHIFT = 28;
  localparam int SETTLE_W = 2;

  localparam logic signed [CF_W-1:0] ROT_ONE = CF_W'(1) << ROT_ONE_SHIFT;
  localparam logic [D_W-1:0] D_MAX = {1'b0, {(D_W-1){1'b1}}};
  localparam logic [D_W-1:0] D_MIN = {1'b1, {(D_W-1){1'b0}}};
  localparam logic [D_W-1:0] COORD_ONE = D_W'(1) << COORD_FRAC_BITS;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

  // jacobian row codes
  localparam logic [ROW_W-1:0] ROW_ROT0  = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_TRN0  = ROW_W'(3);
  localparam logic [ROW_W-1:0] ROW_SCALE = ROW_W'(6);

  // register indexes
  localparam logic [IDX_W-1:0] REG_VX  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_VY  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_VZ  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_VW  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_CEN = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_TRN = IDX_W'(5);

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]      param_index;
    logic signed [D_W-1:0] deriv_x;
    logic signed [D_W-1:0] deriv_y;
    logic signed [D_W-1:0] deriv_z;
    logic                  last_row;
    logic                  params_valid;
    logic                  saturated;
  } out_t;

  typedef logic [CF_W-1:0] coef_t;

  // settled configuration seen by the row datapath
  typedef struct packed {
    coef_t [2:0][2:0][2:0] rot;
    coef_t [2:0][2:0]      rmat;
    logic [V_W-1:0]        absw;
    logic                  wzero;
    logic                  wneg;
    logic                  pvalid;
    logic [CFG_W-1:0]      cen;
    logic [CFG_W-1:0]      trn;
    logic                  settling;
  } cfg_t;

  // one divider lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [V_W-1:0] rem;
    logic [Q_W-1:0] nq;
  } div_lane_t;

  // row control riding along the divider
  typedef struct packed {
    logic                  valid;
    logic [ROW_W-1:0]      row;
    logic [2:0]            neg;
    logic [2:0]            nz;
    logic [2:0]            big;
    logic [2:0][VAL_W-1:0] val;
  } side_t;

  function automatic logic signed [PT_W-1:0] coord_field(input logic [CFG_W-1:0] pk,
                                                         input int k);
    return $signed(pk[k*PT_W +: PT_W]);
  endfunction

endpackage

// ----- sv/svj_cfg.sv -----
`timescale 1ns / 1ps
// svj_cfg: configuration registers and the versor coefficient precompute
// depends on svj_pkg
module svj_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [svj_pkg::IDX_W-1:0] cfg_index,
  input  logic [svj_pkg::CFG_W-1:0] cfg_data,
  output svj_pkg::cfg_t             cfg
);
  import svj_pkg::*;

  logic signed [V_W-1:0] vx_r, vy_r, vz_r, vw_r;
  logic [CFG_W-1:0] cen_r, trn_r;
  logic [SETTLE_W-1:0] settle_r;
  logic signed [PRD_W-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, xw_r, yz_r, yw_r, zw_r;
  logic signed [CF_W-1:0] xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
  coef_t [2:0][2:0][2:0] rot_nxt, rot_r;
  coef_t [2:0][2:0] rmat_nxt, rmat_r;
  logic pvalid_nxt, pvalid_r;
  logic [V_W-1:0] absw_r;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r  <= '0;
      vy_r  <= '0;
      vz_r  <= '0;
      vw_r  <= V_W'(16384);
      cen_r <= '0;
      trn_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VX:  vx_r  <= cfg_data[V_W-1:0];
        REG_VY:  vy_r  <= cfg_data[V_W-1:0];
        REG_VZ:  vz_r  <= cfg_data[V_W-1:0];
        REG_VW:  vw_r  <= cfg_data[V_W-1:0];
        REG_CEN: cen_r <= cfg_data;
        REG_TRN: trn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold off points until the coefficient registers follow a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_CYCLES;
    end else if (cfg_valid) begin
      settle_r <= SETTLE_CYCLES;
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // versor products
  always_ff @(posedge clk) begin
    xx_r <= vx_r * vx_r;
    yy_r <= vy_r * vy_r;
    zz_r <= vz_r * vz_r;
    ww_r <= vw_r * vw_r;
    xy_r <= vx_r * vy_r;
    xz_r <= vx_r * vz_r;
    xw_r <= vx_r * vw_r;
    yz_r <= vy_r * vz_r;
    yw_r <= vy_r * vw_r;
    zw_r <= vz_r * vw_r;
  end

  assign xx = CF_W'(xx_r);
  assign yy = CF_W'(yy_r);
  assign zz = CF_W'(zz_r);
  assign ww = CF_W'(ww_r);
  assign xy = CF_W'(xy_r);
  assign xz = CF_W'(xz_r);
  assign xw = CF_W'(xw_r);
  assign yz = CF_W'(yz_r);
  assign yw = CF_W'(yw_r);
  assign zw = CF_W'(zw_r);

  // quaternion polynomial table and rotation matrix
  always_comb begin
    rot_nxt[0][0][0] = '0;
    rot_nxt[0][0][1] = yw + xz;
    rot_nxt[0][0][2] = zw - xy;
    rot_nxt[0][1][0] = yw - xz;
    rot_nxt[0][1][1] = -(xw <<< 1);
    rot_nxt[0][1][2] = xx - ww;
    rot_nxt[0][2][0] = zw + xy;
    rot_nxt[0][2][1] = ww - xx;
    rot_nxt[0][2][2] = -(xw <<< 1);
    rot_nxt[1][0][0] = -(yw <<< 1);
    rot_nxt[1][0][1] = xw + yz;
    rot_nxt[1][0][2] = ww - yy;
    rot_nxt[1][1][0] = xw - yz;
    rot_nxt[1][1][1] = '0;
    rot_nxt[1][1][2] = zw + xy;
    rot_nxt[1][2][0] = yy - ww;
    rot_nxt[1][2][1] = zw - xy;
    rot_nxt[1][2][2] = -(yw <<< 1);
    rot_nxt[2][0][0] = -(zw <<< 1);
    rot_nxt[2][0][1] = zz - ww;
    rot_nxt[2][0][2] = xw - yz;
    rot_nxt[2][1][0] = ww - zz;
    rot_nxt[2][1][1] = -(zw <<< 1);
    rot_nxt[2][1][2] = yw + xz;
    rot_nxt[2][2][0] = xw + yz;
    rot_nxt[2][2][1] = yw - xz;
    rot_nxt[2][2][2] = '0;
    rmat_nxt[0][0] = ROT_ONE - ((yy + zz) <<< 1);
    rmat_nxt[0][1] = (xy - zw) <<< 1;
    rmat_nxt[0][2] = (xz + yw) <<< 1;
    rmat_nxt[1][0] = (xy + zw) <<< 1;
    rmat_nxt[1][1] = ROT_ONE - ((xx + zz) <<< 1);
    rmat_nxt[1][2] = (yz - xw) <<< 1;
    rmat_nxt[2][0] = (xz - yw) <<< 1;
    rmat_nxt[2][1] = (yz + xw) <<< 1;
    rmat_nxt[2][2] = ROT_ONE - ((xx + yy) <<< 1);
    pvalid_nxt = (xx + yy + zz) <= ROT_ONE;
  end

  always_ff @(posedge clk) begin
    rot_r    <= rot_nxt;
    rmat_r   <= rmat_nxt;
    pvalid_r <= pvalid_nxt;
    absw_r   <= vw_r[V_W-1] ? V_W'(-vw_r) : V_W'(vw_r);
  end

  assign cfg.rot      = rot_r;
  assign cfg.rmat     = rmat_r;
  assign cfg.absw     = absw_r;
  assign cfg.wzero    = (vw_r == '0);
  assign cfg.wneg     = vw_r[V_W-1];
  assign cfg.pvalid   = pvalid_r;
  assign cfg.cen      = cen_r;
  assign cfg.trn      = trn_r;
  assign cfg.settling = cfg_valid || (settle_r != '0);

endmodule

// ----- sv/svj_dot.sv -----
`timescale 1ns / 1ps
// svj_dot: two-stage multiply and sum of one jacobian row against the point offset
// depends on svj_pkg
module svj_dot (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [svj_pkg::ROW_W-1:0]             in_row,
  input  svj_pkg::coef_t [2:0][2:0]             coef,
  input  logic [2:0][svj_pkg::P_W-1:0]          p,
  output logic                                  out_valid,
  output logic [svj_pkg::ROW_W-1:0]             out_row,
  output logic [2:0][svj_pkg::SUM_W-1:0]        sum
);
  import svj_pkg::*;

  logic signed [PR_W-1:0] prod_r [3][3];
  logic c_valid_r, d_valid_r;
  logic [ROW_W-1:0] c_row_r, d_row_r;
  logic [2:0][SUM_W-1:0] sum_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= in_valid;
      d_valid_r <= c_valid_r;
    end
  end

  // nine products, then three sums
  always_ff @(posedge clk) begin
    if (en) begin
      c_row_r <= in_row;
      d_row_r <= c_row_r;
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_r[j][k] <= $signed(coef[j][k]) * $signed(p[k]);
        end
        sum_r[j] <= SUM_W'(prod_r[j][0]) + SUM_W'(prod_r[j][1]) + SUM_W'(prod_r[j][2]);
      end
    end
  end

  assign out_valid = d_valid_r;
  assign out_row   = d_row_r;
  assign sum       = sum_r;

endmodule

// ----- sv/svj_div_stage.sv -----
`timescale 1ns / 1ps
// svj_div_stage: one restoring divider stage, four quotient bits for three lanes
// depends on svj_pkg
module svj_div_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [svj_pkg::V_W-1:0]      absw,
  input  svj_pkg::side_t               side_i,
  input  svj_pkg::div_lane_t [2:0]     lane_i,
  output svj_pkg::side_t               side_o,
  output svj_pkg::div_lane_t [2:0]     lane_o
);
  import svj_pkg::*;

  div_lane_t [2:0] lane_nxt;
  div_lane_t [2:0] lane_r;
  side_t side_r;

  // shift in one dividend bit per step, subtract when it fits
  always_comb begin
    logic [V_W:0] trial;
    logic [V_W-1:0] rem;
    logic [Q_W-1:0] nq;
    trial = '0;
    rem = '0;
    nq = '0;
    for (int j = 0; j < 3; j++) begin
      rem = lane_i[j].rem;
      nq  = lane_i[j].nq;
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {rem, nq[Q_W-1]};
        if (trial >= {1'b0, absw}) begin
          rem = V_W'(trial - {1'b0, absw});
          nq  = {nq[Q_W-2:0], 1'b1};
        end else begin
          rem = trial[V_W-1:0];
          nq  = {nq[Q_W-2:0], 1'b0};
        end
      end
      lane_nxt[j].rem = rem;
      lane_nxt[j].nq  = nq;
    end
  end

  // stage register, valid bit under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r.valid <= side_i.valid;
    end
    if (en) begin
      side_r.row <= side_i.row;
      side_r.neg <= side_i.neg;
      side_r.nz  <= side_i.nz;
      side_r.big <= side_i.big;
      side_r.val <= side_i.val;
      lane_r     <= lane_nxt;
    end
  end

  assign side_o = side_r;
  assign lane_o = lane_r;

endmodule

// ----- sv/similarity3d_versor_jacobian_unit.sv -----
`timescale 1ns / 1ps
// similarity3d_versor_jacobian_unit: top level, row sequencer, divider chain and output
// depends on svj_pkg, svj_cfg, svj_dot, svj_div_stage
//
// Each accepted point yields seven jacobian rows (three rotation, three translation,
// one scale), one row per cycle when the output is not stalled; a new point can be
// taken as the last row of the one before issues. The row sequencer feeds rows into
// a single shared datapath: coefficient select, 34x21 multipliers, three-term sum,
// rounding prep, a nine-stage restoring divider (four quotient bits per stage) by
// |w|, then clipping and the output register. The input stays not ready after reset,
// and during a configuration write and while the settle counter runs down after it,
// as the versor coefficients are recomputed.
module similarity3d_versor_jacobian_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  svj_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output svj_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [svj_pkg::IDX_W-1:0] cfg_index,
  input  logic [svj_pkg::CFG_W-1:0] cfg_data
);
  import svj_pkg::*;

  cfg_t cfg;
  logic en, in_acc, a_last;
  logic a_valid_r;
  logic [ROW_W-1:0] a_row_r;
  logic [2:0][P_W-1:0] a_p_r;
  logic b_valid_r;
  logic [ROW_W-1:0] b_row_r;
  coef_t [2:0][2:0] b_coef_nxt, b_coef_r;
  logic [2:0][P_W-1:0] b_p_r;
  logic dot_valid;
  logic [ROW_W-1:0] dot_row;
  logic [2:0][SUM_W-1:0] dot_sum;
  side_t e_side_nxt;
  div_lane_t [2:0] e_lane_nxt;
  side_t e_side_r;
  div_lane_t [2:0] e_lane_r;
  side_t [DIV_STAGES:0] dv_side;
  div_lane_t [DIV_STAGES:0][2:0] dv_lane;
  side_t f_side;
  logic [2:0][D_W-1:0] f_d;
  logic [2:0] f_sat;
  out_t out_nxt, out_r;
  logic out_valid_r;

  svj_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // the whole row pipeline moves unless the output holds an untaken transaction
  assign en     = !out_valid_r || out_ready;
  assign a_last = (a_row_r == ROW_SCALE);
  assign in_ready = !cfg.settling && (!a_valid_r || (a_last && en));
  assign in_acc = in_valid && in_ready;

  // row sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      a_row_r   <= ROW_ROT0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
      a_row_r   <= ROW_ROT0;
    end else if (a_valid_r && en) begin
      if (a_last) begin
        a_valid_r <= 1'b0;
      end else begin
        a_row_r <= a_row_r + 1'b1;
      end
    end
  end

  // point offset from the rotation center
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_p_r[0] <= P_W'(in_data.point_x) - P_W'(coord_field(cfg.cen, 0));
      a_p_r[1] <= P_W'(in_data.point_y) - P_W'(coord_field(cfg.cen, 1));
      a_p_r[2] <= P_W'(in_data.point_z) - P_W'(coord_field(cfg.cen, 2));
    end
  end

  // coefficient select for the issued row
  always_comb begin
    priority if (a_row_r < ROW_TRN0) begin
      b_coef_nxt = cfg.rot[a_row_r[1:0]];
    end else if (a_row_r == ROW_SCALE) begin
      b_coef_nxt = cfg.rmat;
    end else begin
      b_coef_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_row_r  <= a_row_r;
      b_coef_r <= b_coef_nxt;
      b_p_r    <= a_p_r;
    end
  end

  svj_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .in_row    (b_row_r),
    .coef      (b_coef_r),
    .p         (b_p_r),
    .out_valid (dot_valid),
    .out_row   (dot_row),
    .sum       (dot_sum)
  );

  // rounding prep: rotation dividend and scale row value
  always_comb begin
    logic signed [SUM_W-1:0] s_sum;
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] n;
    logic [NUM_W-1:0] m;
    logic [DIVN_W-1:0] dvd;
    logic [SUM_W-1:0] am;
    logic signed [VAL_W-1:0] qv;
    logic signed [VAL_W-1:0] sv;
    s_sum = '0;
    num = '0;
    n = '0;
    m = '0;
    dvd = '0;
    am = '0;
    qv = '0;
    sv = '0;
    e_side_nxt.valid = dot_valid;
    e_side_nxt.row   = dot_row;
    for (int j = 0; j < 3; j++) begin
      s_sum = $signed(dot_sum[j]);
      num = NUM_W'(s_sum) <<< 1;
      n = cfg.wneg ? -num : num;
      e_side_nxt.neg[j] = n[NUM_W-1];
      e_side_nxt.nz[j]  = (n != '0);
      m = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
      dvd = DIVN_W'((m + (NUM_W'(cfg.absw) << (DEN_SHIFT - 1))) >> DEN_SHIFT);
      e_side_nxt.big[j] = V_W'(dvd[DIVN_W-1:Q_W]) >= cfg.absw;
      e_lane_nxt[j].rem = V_W'(dvd[DIVN_W-1:Q_W]);
      e_lane_nxt[j].nq  = dvd[Q_W-1:0];
      am = s_sum[SUM_W-1] ? SUM_W'(-s_sum) : SUM_W'(s_sum);
      qv = VAL_W'((am + (SUM_W'(1) << (ROT_ONE_SHIFT - 1))) >> ROT_ONE_SHIFT);
      sv = s_sum[SUM_W-1] ? -qv : qv;
      e_side_nxt.val[j] = sv + VAL_W'(coord_field(cfg.trn, j))
                             + VAL_W'(coord_field(cfg.cen, j));
    end
  end

  // prep register, valid bit under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_side_r.valid <= 1'b0;
    end else if (en) begin
      e_side_r.valid <= e_side_nxt.valid;
    end
    if (en) begin
      e_side_r.row <= e_side_nxt.row;
      e_side_r.neg <= e_side_nxt.neg;
      e_side_r.nz  <= e_side_nxt.nz;
      e_side_r.big <= e_side_nxt.big;
      e_side_r.val <= e_side_nxt.val;
      e_lane_r     <= e_lane_nxt;
    end
  end

  assign dv_side[0] = e_side_r;
  assign dv_lane[0] = e_lane_r;

  // divider chain
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    svj_div_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .absw   (cfg.absw),
      .side_i (dv_side[g]),
      .lane_i (dv_lane[g]),
      .side_o (dv_side[g+1]),
      .lane_o (dv_lane[g+1])
    );
  end

  assign f_side = dv_side[DIV_STAGES];

  // sign, clipping and row values
  always_comb begin
    logic [Q_W-1:0] q;
    logic signed [VAL_W-1:0] v;
    q = '0;
    v = '0;
    for (int j = 0; j < 3; j++) begin
      q = dv_lane[DIV_STAGES][j].nq;
      v = $signed(f_side.val[j]);
      f_d[j] = '0;
      f_sat[j] = 1'b0;
      priority if (f_side.row < ROW_TRN0) begin
        priority if (cfg.wzero) begin
          f_sat[j] = 1'b1;
          f_d[j] = f_side.nz[j] ? (f_side.neg[j] ? D_MIN : D_MAX) : '0;
        end else if (f_side.neg[j]) begin
          if (f_side.big[j] || (q > Q_W'(D_MIN))) begin
            f_sat[j] = 1'b1;
            f_d[j] = D_MIN;
          end else begin
            f_d[j] = D_W'(Q_W'(0) - q);
          end
        end else begin
          if (f_side.big[j] || (q > Q_W'(D_MAX))) begin
            f_sat[j] = 1'b1;
            f_d[j] = D_MAX;
          end else begin
            f_d[j] = D_W'(q);
          end
        end
      end else if (f_side.row == ROW_SCALE) begin
        priority if (v > $signed(VAL_W'(D_MAX))) begin
          f_sat[j] = 1'b1;
          f_d[j] = D_MAX;
        end else if (v < VAL_W'($signed(D_MIN))) begin
          f_sat[j] = 1'b1;
          f_d[j] = D_MIN;
        end else begin
          f_d[j] = D_W'(v);
        end
      end else begin
        f_d[j] = (f_side.row == ROW_TRN0 + ROW_W'(j)) ? COORD_ONE : '0;
      end
    end
    out_nxt.param_index  = f_side.row;
    out_nxt.deriv_x      = f_d[0];
    out_nxt.deriv_y      = f_d[1];
    out_nxt.deriv_z      = f_d[2];
    out_nxt.last_row     = (f_side.row == ROW_SCALE);
    out_nxt.params_valid = cfg.pvalid;
    out_nxt.saturated    = |f_sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= f_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for similarity3d_versor_jacobian_unit, jacobian rows per point
// depends on svj_pkg and the unit; predicts every row in 64-bit fixed point and checks in order
module tb_top;
  import svj_pkg::*;

  // index with no register behind it
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(6);

  // jacobian row predictor and store of pending rows
  class jacobian_board;
    longint vx, vy, vz, vw;
    logic [59:0] cen, trn;
    out_t rows_due[$];
    int errors;

    function new();
      vx = 0; vy = 0; vz = 0; vw = 16384; cen = '0; trn = '0; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [59:0] v);
      case (idx)
        REG_VX: vx = longint'($signed(v[15:0]));
        REG_VY: vy = longint'($signed(v[15:0]));
        REG_VZ: vz = longint'($signed(v[15:0]));
        REG_VW: vw = longint'($signed(v[15:0]));
        REG_CEN: cen = v;
        REG_TRN: trn = v;
        default: ;
      endcase
    endfunction

    function longint rnd_div(longint n, longint d);
      longint m;
      longint q;
      m = n < 0 ? -n : n;
      q = (m + d / 2) / d;
      return n < 0 ? -q : q;
    endfunction

    function longint clip(longint v, ref bit s);
      if (v > 64'sd2147483647) begin s = 1; return 64'sd2147483647; end
      if (v < -64'sd2147483648) begin s = 1; return -64'sd2147483648; end
      return v;
    endfunction

    function void note_point(in_t pt);
      longint p[3], c[3], t[3], co[3][3][3], r[3][3], d[3];
      longint xx, yy, zz, ww, xy, xz, xw, yz, yw, zw, one, num, acc;
      bit ok, s;
      out_t o;
      for (int i = 0; i < 3; i++) begin
        c[i] = longint'($signed(cen[20*i +: 20]));
        t[i] = longint'($signed(trn[20*i +: 20]));
      end
      p[0] = longint'(pt.point_x) - c[0];
      p[1] = longint'(pt.point_y) - c[1];
      p[2] = longint'(pt.point_z) - c[2];
      xx = vx*vx; yy = vy*vy; zz = vz*vz; ww = vw*vw;
      xy = vx*vy; xz = vx*vz; xw = vx*vw; yz = vy*vz; yw = vy*vw; zw = vz*vw;
      one = 64'sd1 << 28;
      co = '{'{'{0, yw+xz, zw-xy}, '{yw-xz, -2*xw, xx-ww}, '{zw+xy, ww-xx, -2*xw}},
             '{'{-2*yw, xw+yz, ww-yy}, '{xw-yz, 0, zw+xy}, '{yy-ww, zw-xy, -2*yw}},
             '{'{-2*zw, zz-ww, xw-yz}, '{ww-zz, -2*zw, yw+xz}, '{xw+yz, yw-xz, 0}}};
      r = '{'{one-2*(yy+zz), 2*(xy-zw), 2*(xz+yw)},
            '{2*(xy+zw), one-2*(xx+zz), 2*(yz-xw)},
            '{2*(xz-yw), 2*(yz+xw), one-2*(xx+yy)}};
      ok = (xx + yy + zz) <= one;
      // rotation rows
      for (int i = 0; i < 3; i++) begin
        s = 0;
        for (int j = 0; j < 3; j++) begin
          num = 0;
          for (int k = 0; k < 3; k++) num += co[i][j][k] * p[k];
          num *= 2;
          if (vw == 0) begin
            s = 1;
            d[j] = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
          end else
            d[j] = clip(rnd_div(vw < 0 ? -num : num, (vw < 0 ? -vw : vw) * 16384), s);
        end
        o = '{ROW_W'(i), d[0][31:0], d[1][31:0], d[2][31:0], 1'b0, ok, s};
        rows_due.push_back(o);
      end
      // translation rows
      for (int i = 0; i < 3; i++) begin
        o = '{ROW_TRN0 + ROW_W'(i), (i == 0) ? COORD_ONE : '0, (i == 1) ? COORD_ONE : '0,
              (i == 2) ? COORD_ONE : '0, 1'b0, ok, 1'b0};
        rows_due.push_back(o);
      end
      // scale row
      s = 0;
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += r[j][k] * p[k];
        d[j] = clip(rnd_div(acc, one) + t[j] + c[j], s);
      end
      o = '{ROW_SCALE, d[0][31:0], d[1][31:0], d[2][31:0], 1'b1, ok, s};
      rows_due.push_back(o);
    endfunction

    // one line per mismatch, counted
    task report(string msg);
      $display("tb_top: %s", msg);
      errors++;
    endtask

    task check_row(out_t got);
      out_t w;
      if (rows_due.size() == 0) begin
        report($sformatf("unexpected row %0d", got.param_index));
        return;
      end
      w = rows_due.pop_front();
      if (got !== w)
        report($sformatf("row %0d mismatch: got %h want %h", w.param_index, got, w));
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic in_ready, out_valid, cfg_ready;
  in_t in_data = '0;
  out_t out_data;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  jacobian_board board = new();
  int hold_off = 0;
  int out_wait = 0;
  int rows_seen = 0;

  always #6 clk = ~clk;

  similarity3d_versor_jacobian_unit uut (.*);

  // result side: idle gap drawn per transaction plus a long hold-off when asked
  always @(posedge clk) begin
    int w;
    w = 0;
    if (rst_n && out_valid && out_ready) begin
      board.check_row(out_data);
      rows_seen++;
      w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        out_wait <= w;
        out_ready <= (w == 0);
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ready <= (out_wait == 1);
      end else
        out_ready <= 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [59:0] v);
    cfg_index <= idx; cfg_data <= v; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_point(in_t pt, bit gaps);
    int g;
    g = gaps ? (($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_data <= pt; in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    board.note_point(pt);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.rows_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [59:0] rnd_coords(int span);
    logic [59:0] v;
    for (int k = 0; k < 3; k++)
      v[20*k +: 20] = 20'($signed($urandom_range(0, 2*span)) - span);
    return v;
  endfunction

  function automatic in_t rnd_point();
    in_t pt;
    case ($urandom_range(0, 3))
      0: pt = in_t'({$urandom, $urandom});
      default: begin
        pt.point_x = 20'($urandom_range(0, 8000) - 4000);
        pt.point_y = 20'($urandom_range(0, 8000) - 4000);
        pt.point_z = 20'($urandom_range(0, 8000) - 4000);
      end
    endcase
    return pt;
  endfunction

  // versor settings: identity, extremes, zero w, negative w, random
  task automatic set_versor(int mode);
    logic [15:0] x, y, z, w;
    case (mode)
      0: begin x = '0; y = '0; z = '0; w = 16'd16384; end
      1: begin x = 16'h4000; y = '0; z = '0; w = '0; end
      2: begin x = 16'hC000; y = 16'hC000; z = 16'hC000; w = 16'hC000; end
      3: begin x = 16'h7FFF; y = 16'h8000; z = 16'h7FFF; w = 16'h0001; end
      4: begin x = 16'h2000; y = 16'hE000; z = 16'h1000; w = 16'hD000; end
      default: begin
        x = 16'($urandom_range(0, 16384) - 8192);
        y = 16'($urandom_range(0, 16384) - 8192);
        z = 16'($urandom_range(0, 16384) - 8192);
        w = 16'($urandom_range(0, 32768) - 16384);
        if ($urandom_range(0, 5) == 0) w = 16'($urandom);
      end
    endcase
    write_reg(REG_VX, 60'(x)); write_reg(REG_VY, 60'(y));
    write_reg(REG_VZ, 60'(z)); write_reg(REG_VW, 60'(w));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: identity, field extremes, then versor corners
    send_point('{20'h7FFFF, 20'h80000, 20'h00000}, 0);
    send_point('{20'h80000, 20'h7FFFF, 20'hFFFFF}, 0);
    send_point('{20'h00100, 20'h00200, 20'hFFF00}, 0);
    drain();
    write_reg(REG_CEN, {20'h80000, 20'h7FFFF, 20'h00100});
    write_reg(REG_TRN, {20'h7FFFF, 20'h7FFFF, 20'h80000});
    for (int m = 1; m <= 4; m++) begin
      set_versor(m);
      send_point('{20'h7FFFF, 20'h7FFFF, 20'h7FFFF}, 0);
      send_point('{20'h80000, 20'h80000, 20'h80000}, 0);
      send_point('{20'h00000, 20'h00000, 20'h00000}, 0);
      send_point('{20'h00080, 20'hFFF80, 20'h00001}, 0);
      drain();
    end
    write_reg(REG_VX, 60'hFFFF_FFFF_FFF_FFFF);
    write_reg(REG_UNUSED, 60'h5);
    drain();
    // random phases; the second one holds the receiver off for a long stretch
    for (int ph = 0; ph < 6; ph++) begin
      set_versor(ph == 0 ? 0 : 5);
      write_reg(REG_CEN, ph[0] ? rnd_coords(524288) : rnd_coords(3000));
      write_reg(REG_TRN, ph[1] ? 60'({$urandom, $urandom}) : rnd_coords(3000));
      if (ph == 1) hold_off = 300;
      for (int n = 0; n < 18; n++) send_point(rnd_point(), ph != 1);
      drain();
    end
    $display("tb_top: %0d rows checked over identity, extreme, zero-w and random versors",
             rows_seen);
    if (board.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
